// File: rtl/core/keycode_to_char_sticky_modifiers_top_macros.svh
// Assertion helpers for the key translator.
`ifndef KEYCODE_TO_CHAR_STICKY_MODIFIERS_TOP_MACROS_SVH
`define KEYCODE_TO_CHAR_STICKY_MODIFIERS_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define KCSM_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("keycode_to_char_sticky_modifiers_top: same-cycle check failed");

// Next-cycle implication, ignored while reset is held.
`define KCSM_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("keycode_to_char_sticky_modifiers_top: next-cycle check failed");

`endif

// File: rtl/core/kcsm_pkg.sv
package kcsm_pkg;

  typedef struct packed {
    logic       key_down;
    logic [6:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       pressed;
    logic [6:0] hid_code;
    logic [1:0] modifier_bits;
    logic       last_of_pair;
  } out_item_t;

  // One queued key-down: both halves of the pair are built from it
  typedef struct packed {
    logic [7:0] char_code;
    logic [6:0] hid_code;
    logic [1:0] modifier_bits;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int CFG_DATA_W = 8;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_SHIFT_KEY = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FN_KEY    = 1'd1;

  localparam logic [7:0] SHIFT_KEY_RESET = 8'hE1;
  localparam logic [6:0] FN_KEY_RESET    = 7'h3A;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_LOCK = 2'd2;

  localparam logic [1:0] MOD_SHIFT = 2'd2;
  localparam logic [1:0] MOD_NONE  = 2'd0;

  localparam logic [6:0] CODE_MENU = 7'h44;
  localparam logic [6:0] CODE_FILE = 7'h43;

  localparam logic [6:0] CODE_A      = 7'h04;
  localparam logic [6:0] CODE_Z      = 7'h1D;
  localparam logic [6:0] CODE_RIGHT  = 7'h4F;
  localparam logic [6:0] CODE_LEFT   = 7'h50;
  localparam logic [6:0] CODE_DOWN   = 7'h51;
  localparam logic [6:0] CODE_UP     = 7'h52;
  localparam logic [6:0] CODE_KP_1   = 7'h59;
  localparam logic [6:0] CODE_KP_9   = 7'h61;

  localparam logic [7:0] LAYER_GLYPHS [26] = '{
    8'h7C, 8'h3E, 8'h7E, 8'h2C, 8'h40, 8'h3F, 8'h27, 8'h3A, 8'h26, 8'h3B,
    8'h7B, 8'h7D, 8'h5D, 8'h5B, 8'h28, 8'h29, 8'h21, 8'hA3, 8'h23, 8'h24,
    8'h5E, 8'h3C, 8'h22, 8'h5C, 8'h25, 8'h00
  };

  function automatic logic [1:0] step_mode(input logic [1:0] m);
    logic [1:0] r;
    begin
      unique case (m)
        MODE_OFF: r = MODE_ONE;
        MODE_ONE: r = MODE_LOCK;
        default:  r = MODE_OFF;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] translate(input logic [6:0] code, input logic shift,
                                           input logic fn);
    logic [4:0] idx;
    logic [7:0] ch;
    begin
      idx = 5'(code - CODE_A);
      ch  = 8'h00;
      if (code >= CODE_A && code <= CODE_Z) begin
        if (fn && LAYER_GLYPHS[idx] != 8'h00) ch = LAYER_GLYPHS[idx];
        else ch = (shift ? 8'h41 : 8'h61) + {3'b000, idx};
      end else if (fn && code == CODE_RIGHT) begin
        ch = 8'd3;   // End
      end else if (fn && code == CODE_LEFT) begin
        ch = 8'd2;   // Home
      end else if (fn && (code == CODE_DOWN || code == CODE_UP)) begin
        ch = 8'h00;
      end else begin
        unique case (code)
          7'h28:      ch = 8'd10;
          7'h29:      ch = 8'd27;
          7'h2A:      ch = 8'd8;
          7'h2C:      ch = 8'h20;
          7'h2E:      ch = 8'h3D;
          7'h37:      ch = 8'h2E;
          CODE_RIGHT: ch = 8'd19;
          CODE_LEFT:  ch = 8'd20;
          CODE_DOWN:  ch = 8'd18;
          CODE_UP:    ch = 8'd17;
          7'h54:      ch = 8'h2F;
          7'h55:      ch = 8'h2A;
          7'h56:      ch = 8'h2D;
          7'h57:      ch = 8'h2B;
          7'h58:      ch = 8'd10;
          7'h62:      ch = 8'h30;
          7'h63:      ch = 8'h2E;
          default: begin
            if (code >= CODE_KP_1 && code <= CODE_KP_9)
              ch = 8'h31 + {1'b0, 7'(code - CODE_KP_1)};
            else
              ch = 8'h00;
          end
        endcase
      end
      return ch;
    end
  endfunction

endpackage

// File: rtl/core/keycode_to_char_sticky_modifiers_top.sv
// Key event translator with sticky Shift and Fn modes. Push raw key events
// (down flag, 7-bit HID code); every key-down other than the shift or Fn key
// yields a press result followed by a release result, popped from the result
// side. Up to one event is taken per cycle until the internal queue of QUEUE_DEPTH
// key-downs fills; key-ups and shift/Fn presses give nothing.
// The output register issues one result per cycle while results are popped, so
// each translated key-down leaves that single register as a press/release pair.
// The first result passes through the queue and then the output register before
// it shows on the result ports, and can be popped while it shows there.
// Write the key-code registers only while the block is idle.
`include "keycode_to_char_sticky_modifiers_top_macros.svh"

module keycode_to_char_sticky_modifiers_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  kcsm_pkg::in_item_t                  in_data,
  output logic                                out_empty,
  input  logic                                out_pop,
  output kcsm_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [kcsm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [kcsm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  kcsm_pkg::q_stat_t q_stat;
  kcsm_pkg::pair_t   q_wdata;
  kcsm_pkg::pair_t   q_rdata;
  logic              q_push;
  logic              q_pop;
  logic              press_taken;
  logic              release_shown;

  assign in_full = q_stat.full;

  kcsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  kcsm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  kcsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  assign press_taken   = !out_empty && out_pop && out_data.pressed;
  assign release_shown = !out_empty && out_data.last_of_pair;

  `KCSM_ASSERT_NEXT(a_release_follows_press, clk, rst_n, press_taken, release_shown && $stable(out_data.hid_code))
  `KCSM_ASSERT_NOW(a_key_up_no_push, clk, rst_n, in_push && !in_full && !in_data.key_down, !q_push)
  `KCSM_ASSERT_NOW(a_no_push_when_full, clk, rst_n, q_stat.full, !q_push)

endmodule

// File: rtl/core/kcsm_front.sv
module kcsm_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  input  kcsm_pkg::in_item_t                     in_data,
  input  logic                                   cfg_we,
  input  logic [kcsm_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [kcsm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  kcsm_pkg::q_stat_t                      q_stat,
  output logic                                   q_push,
  output kcsm_pkg::pair_t                        q_wdata
);

  logic [7:0] shift_key_r, shift_key_nxt;
  logic [6:0] fn_key_r, fn_key_nxt;
  logic [1:0] shift_mode_r, shift_mode_nxt;
  logic [1:0] layer_mode_r, layer_mode_nxt;

  logic accept;
  logic hit_shift;
  logic hit_fn;
  logic is_menu;
  logic shift_on;
  logic layer_on;

  assign accept    = in_push && !q_stat.full && in_data.key_down;
  assign hit_shift = {1'b0, in_data.key_code} == shift_key_r;
  assign hit_fn    = in_data.key_code == fn_key_r;
  assign is_menu   = in_data.key_code == kcsm_pkg::CODE_MENU ||
                     in_data.key_code == kcsm_pkg::CODE_FILE;
  assign shift_on  = shift_mode_r != kcsm_pkg::MODE_OFF;
  assign layer_on  = layer_mode_r != kcsm_pkg::MODE_OFF;

  assign q_push = accept && !hit_shift && !hit_fn;

  always_comb begin
    q_wdata.hid_code      = in_data.key_code;
    q_wdata.modifier_bits = shift_on ? kcsm_pkg::MOD_SHIFT : kcsm_pkg::MOD_NONE;
    q_wdata.char_code     = is_menu ? 8'h00
                          : kcsm_pkg::translate(in_data.key_code, shift_on, layer_on);
  end

  always_comb begin
    shift_key_nxt  = shift_key_r;
    fn_key_nxt     = fn_key_r;
    shift_mode_nxt = shift_mode_r;
    layer_mode_nxt = layer_mode_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        kcsm_pkg::CFG_SHIFT_KEY: shift_key_nxt = cfg_wdata;
        kcsm_pkg::CFG_FN_KEY:    fn_key_nxt    = cfg_wdata[6:0];
        default: ;
      endcase
    end
    if (accept) begin
      if (hit_shift) begin
        shift_mode_nxt = kcsm_pkg::step_mode(shift_mode_r);
      end else if (hit_fn) begin
        layer_mode_nxt = kcsm_pkg::step_mode(layer_mode_r);
      end else if (!is_menu) begin
        // one-press modes are spent by a translated key
        if (shift_mode_r == kcsm_pkg::MODE_ONE) shift_mode_nxt = kcsm_pkg::MODE_OFF;
        if (layer_mode_r == kcsm_pkg::MODE_ONE) layer_mode_nxt = kcsm_pkg::MODE_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_key_r  <= kcsm_pkg::SHIFT_KEY_RESET;
      fn_key_r     <= kcsm_pkg::FN_KEY_RESET;
      shift_mode_r <= kcsm_pkg::MODE_OFF;
      layer_mode_r <= kcsm_pkg::MODE_OFF;
    end else begin
      shift_key_r  <= shift_key_nxt;
      fn_key_r     <= fn_key_nxt;
      shift_mode_r <= shift_mode_nxt;
      layer_mode_r <= layer_mode_nxt;
    end
  end

endmodule

// File: rtl/core/kcsm_queue.sv
module kcsm_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kcsm_pkg::pair_t   wdata,
  input  logic              pop,
  output kcsm_pkg::pair_t   rdata,
  output kcsm_pkg::q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  kcsm_pkg::pair_t  entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = count_r == FULL_CNT;
  assign stat.empty = count_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries_r[wr_ptr_r] <= wdata;
  end

endmodule

// File: rtl/core/kcsm_back.sv
module kcsm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  kcsm_pkg::q_stat_t   q_stat,
  input  kcsm_pkg::pair_t     q_rdata,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output kcsm_pkg::out_item_t out_data
);

  kcsm_pkg::pair_t pair_r, pair_nxt;
  logic            valid_r, valid_nxt;
  logic            release_r, release_nxt;   // press already taken, release showing
  logic            taken;

  assign taken     = valid_r && out_pop;
  assign q_pop     = !q_stat.empty && (!valid_r || (taken && release_r));
  assign out_empty = !valid_r;

  always_comb begin
    out_data.char_code     = pair_r.char_code;
    out_data.pressed       = !release_r;
    out_data.hid_code      = pair_r.hid_code;
    out_data.modifier_bits = pair_r.modifier_bits;
    out_data.last_of_pair  = release_r;
  end

  always_comb begin
    pair_nxt    = pair_r;
    valid_nxt   = valid_r;
    release_nxt = release_r;
    if (taken && !release_r) begin
      release_nxt = 1'b1;
    end else if (q_pop) begin
      pair_nxt    = q_rdata;
      valid_nxt   = 1'b1;
      release_nxt = 1'b0;
    end else if (taken) begin
      valid_nxt   = 1'b0;
      release_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      release_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      release_r <= release_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pair_r <= pair_nxt;
  end

endmodule

// File: dv/keycode_to_char_sticky_modifiers_tb.sv
`timescale 1ns / 100ps

module testbench;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_EVENTS  = 205;
  localparam int RANDOM_PHASES = 9;

  // One step of the directed script: either a key event or a key-register update
  typedef struct packed {
    logic               is_cfg;
    logic [7:0]         shift_val;
    logic [6:0]         fn_val;
    kcsm_pkg::in_item_t ev;
    logic               typed;
    logic [7:0]         ch;
  } script_row_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_push   = 1'b0;
  logic                            in_full;
  kcsm_pkg::in_item_t              in_data   = '0;
  logic                            out_empty;
  logic                            out_pop   = 1'b0;
  kcsm_pkg::out_item_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [kcsm_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [kcsm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Translator state as the testbench sees it
  logic [7:0] shift_key  = kcsm_pkg::SHIFT_KEY_RESET;
  logic [6:0] fn_key     = kcsm_pkg::FN_KEY_RESET;
  logic [1:0] shift_mode = kcsm_pkg::MODE_OFF;
  logic [1:0] layer_mode = kcsm_pkg::MODE_OFF;

  kcsm_pkg::out_item_t pending_chars[$];
  script_row_t         script[$];

  int send_idle_pct = 0;
  int pop_idle_pct  = 0;
  int mismatches    = 0;
  int stall_cycles  = 0;

  always #1 clk = ~clk;

  keycode_to_char_sticky_modifiers_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  function automatic logic [1:0] next_mode(input logic [1:0] m);
    case (m)
      kcsm_pkg::MODE_OFF: return kcsm_pkg::MODE_ONE;
      kcsm_pkg::MODE_ONE: return kcsm_pkg::MODE_LOCK;
      default:            return kcsm_pkg::MODE_OFF;
    endcase
  endfunction

  // Symbol layer over the letter keys; 0 means no symbol (falls back to the letter)
  function automatic logic [7:0] fn_symbol(input logic [4:0] idx);
    case (idx)
      5'd0:  return 8'h7C;  5'd1:  return 8'h3E;  5'd2:  return 8'h7E;
      5'd3:  return 8'h2C;  5'd4:  return 8'h40;  5'd5:  return 8'h3F;
      5'd6:  return 8'h27;  5'd7:  return 8'h3A;  5'd8:  return 8'h26;
      5'd9:  return 8'h3B;  5'd10: return 8'h7B;  5'd11: return 8'h7D;
      5'd12: return 8'h5D;  5'd13: return 8'h5B;  5'd14: return 8'h28;
      5'd15: return 8'h29;  5'd16: return 8'h21;  5'd17: return 8'hA3;
      5'd18: return 8'h23;  5'd19: return 8'h24;  5'd20: return 8'h5E;
      5'd21: return 8'h3C;  5'd22: return 8'h22;  5'd23: return 8'h5C;
      5'd24: return 8'h25;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] key_char(input logic [6:0] code, input logic shifted,
                                          input logic fn_on);
    logic [4:0] idx;
    idx = code[4:0] - kcsm_pkg::CODE_A[4:0];
    if (code >= kcsm_pkg::CODE_A && code <= kcsm_pkg::CODE_Z) begin
      if (fn_on && fn_symbol(idx) != 8'h00) return fn_symbol(idx);
      return (shifted ? 8'h41 : 8'h61) + {3'b000, idx};
    end
    if (fn_on) begin
      if (code == kcsm_pkg::CODE_RIGHT) return 8'd3;   // End
      if (code == kcsm_pkg::CODE_LEFT) return 8'd2;    // Home
      if (code == kcsm_pkg::CODE_DOWN || code == kcsm_pkg::CODE_UP) return 8'h00;
    end
    case (code)
      7'h28:                return 8'd10;
      7'h29:                return 8'd27;
      7'h2A:                return 8'd8;
      7'h2C:                return 8'h20;
      7'h2E:                return 8'h3D;
      7'h37:                return 8'h2E;
      kcsm_pkg::CODE_RIGHT: return 8'd19;
      kcsm_pkg::CODE_LEFT:  return 8'd20;
      kcsm_pkg::CODE_DOWN:  return 8'd18;
      kcsm_pkg::CODE_UP:    return 8'd17;
      7'h54:                return 8'h2F;
      7'h55:                return 8'h2A;
      7'h56:                return 8'h2D;
      7'h57:                return 8'h2B;
      7'h58:                return 8'd10;
      7'h62:                return 8'h30;
      7'h63:                return 8'h2E;
      default: begin
        if (code >= kcsm_pkg::CODE_KP_1 && code <= kcsm_pkg::CODE_KP_9)
          return 8'h31 + {1'b0, code - kcsm_pkg::CODE_KP_1};
        return 8'h00;
      end
    endcase
  endfunction

  // Updates the sticky modes and queues the press/release pair, if any.
  // A typed character overrides the computed one for hand-checked rows.
  task automatic predict_event(input kcsm_pkg::in_item_t ev, input logic typed,
                               input logic [7:0] ch_typed);
    logic [1:0]          mod;
    logic [7:0]          ch;
    kcsm_pkg::out_item_t r;
    if (!ev.key_down) return;
    if ({1'b0, ev.key_code} == shift_key) begin
      shift_mode = next_mode(shift_mode);
      return;
    end
    if (ev.key_code == fn_key) begin
      layer_mode = next_mode(layer_mode);
      return;
    end
    mod = (shift_mode != kcsm_pkg::MODE_OFF) ? kcsm_pkg::MOD_SHIFT : kcsm_pkg::MOD_NONE;
    if (ev.key_code == kcsm_pkg::CODE_MENU || ev.key_code == kcsm_pkg::CODE_FILE) begin
      ch = 8'h00;
    end else begin
      ch = key_char(ev.key_code, shift_mode != kcsm_pkg::MODE_OFF,
                    layer_mode != kcsm_pkg::MODE_OFF);
      if (shift_mode == kcsm_pkg::MODE_ONE) shift_mode = kcsm_pkg::MODE_OFF;
      if (layer_mode == kcsm_pkg::MODE_ONE) layer_mode = kcsm_pkg::MODE_OFF;
    end
    if (typed) ch = ch_typed;
    r.char_code     = ch;
    r.pressed       = 1'b1;
    r.hid_code      = ev.key_code;
    r.modifier_bits = mod;
    r.last_of_pair  = 1'b0;
    pending_chars.push_back(r);
    r.pressed      = 1'b0;
    r.last_of_pair = 1'b1;
    pending_chars.push_back(r);
  endtask

  task automatic send_event(input kcsm_pkg::in_item_t ev, input logic typed,
                            input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_full);
    predict_event(ev, typed, ch);
  endtask

  // Drain everything, let the block settle, then write both key registers
  task automatic write_keys(input logic [7:0] shift_val, input logic [6:0] fn_val);
    in_push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= kcsm_pkg::CFG_SHIFT_KEY;
    cfg_wdata <= shift_val;
    @(posedge clk);
    cfg_addr  <= kcsm_pkg::CFG_FN_KEY;
    cfg_wdata <= {1'b0, fn_val};
    @(posedge clk);
    cfg_we    <= 1'b0;
    shift_key = shift_val;
    fn_key    = fn_val;
  endtask

  function automatic kcsm_pkg::in_item_t pick_event();
    kcsm_pkg::in_item_t ev;
    int                 r;
    r = $urandom_range(99);
    ev.key_down = 1'b1;
    ev.key_code = 7'($urandom_range(127));
    if (r < 12) begin
      ev.key_down = 1'b0;
    end else if (r < 22) begin
      ev.key_code = shift_key[6:0];
    end else if (r < 32) begin
      ev.key_code = fn_key;
    end else if (r < 37) begin
      ev.key_code = $urandom_range(1) ? kcsm_pkg::CODE_MENU : kcsm_pkg::CODE_FILE;
    end else if (r < 50) begin
      ev.key_down = 1'($urandom_range(1));
    end else begin
      case ($urandom_range(3))
        0:       ev.key_code = kcsm_pkg::CODE_A + 7'($urandom_range(25));
        1:       ev.key_code = kcsm_pkg::CODE_RIGHT + 7'($urandom_range(3));
        2:       ev.key_code = 7'h54 + 7'($urandom_range(15));   // keypad block
        default: ev.key_code = 7'h28 + 7'($urandom_range(15));   // editing keys
      endcase
    end
    return ev;
  endfunction

  function automatic void key_row(input logic down, input logic [6:0] code, input logic typed,
                                  input logic [7:0] ch);
    script_row_t row;
    row              = '0;
    row.ev.key_down  = down;
    row.ev.key_code  = code;
    row.typed        = typed;
    row.ch           = ch;
    script.push_back(row);
  endfunction

  function automatic void keymap_row(input logic [7:0] shift_val, input logic [6:0] fn_val);
    script_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.shift_val = shift_val;
    row.fn_val    = fn_val;
    script.push_back(row);
  endfunction

  task automatic check_result(input kcsm_pkg::out_item_t got);
    kcsm_pkg::out_item_t want;
    if (pending_chars.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result transaction: %h", got);
      return;
    end
    want = pending_chars.pop_front();
    if (got.char_code !== want.char_code || got.pressed !== want.pressed ||
        got.hid_code !== want.hid_code || got.modifier_bits !== want.modifier_bits ||
        got.last_of_pair !== want.last_of_pair) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: exp char %h prs %b hid %h mod %h last %b, ",
                  "got char %h prs %b hid %h mod %h last %b"},
                 want.char_code, want.pressed, want.hid_code, want.modifier_bits,
                 want.last_of_pair, got.char_code, got.pressed, got.hid_code,
                 got.modifier_bits, got.last_of_pair);
    end
  endtask

  // Result side: check, throttle pop, and watch for a hang
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) stall_cycles = 0;
    else stall_cycles++;
    if (rst_n) begin
      if (out_pop && !out_empty) check_result(out_data);
      out_pop <= ($urandom_range(99) >= pop_idle_pct);
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL keycode_to_char_sticky_modifiers_top");
      $finish;
    end
  end

  initial begin
    script_row_t row;
    int          i;
    int          p;

    // reset key codes: 0x61 is 0xE1 cut to 7 bits and must not step shift
    key_row(1'b1, kcsm_pkg::CODE_A, 1'b1, 8'h61);
    key_row(1'b1, 7'h61, 1'b1, 8'h39);
    key_row(1'b1, 7'h7F, 1'b1, 8'h00);
    key_row(1'b1, 7'h00, 1'b1, 8'h00);
    key_row(1'b1, kcsm_pkg::CODE_MENU, 1'b1, 8'h00);
    key_row(1'b1, kcsm_pkg::CODE_FILE, 1'b1, 8'h00);
    key_row(1'b1, kcsm_pkg::CODE_RIGHT, 1'b1, 8'd19);
    key_row(1'b0, 7'h7F, 1'b0, 8'h00);
    // one-press Fn: z has no symbol, then locked Fn over arrows and a symbol
    key_row(1'b1, kcsm_pkg::FN_KEY_RESET, 1'b0, 8'h00);
    key_row(1'b1, kcsm_pkg::CODE_Z, 1'b0, 8'h00);
    key_row(1'b1, kcsm_pkg::FN_KEY_RESET, 1'b0, 8'h00);
    key_row(1'b1, kcsm_pkg::FN_KEY_RESET, 1'b0, 8'h00);
    key_row(1'b1, kcsm_pkg::CODE_LEFT, 1'b0, 8'h00);
    key_row(1'b1, kcsm_pkg::CODE_DOWN, 1'b0, 8'h00);
    key_row(1'b1, 7'h15, 1'b0, 8'h00);
    key_row(1'b1, kcsm_pkg::FN_KEY_RESET, 1'b0, 8'h00);
    // Fn moved onto Menu: the Fn match wins
    keymap_row(8'h02, kcsm_pkg::CODE_MENU);
    key_row(1'b1, 7'h02, 1'b0, 8'h00);
    key_row(1'b1, kcsm_pkg::CODE_MENU, 1'b0, 8'h00);
    key_row(1'b1, kcsm_pkg::CODE_A, 1'b0, 8'h00);
    key_row(1'b1, 7'h02, 1'b0, 8'h00);
    key_row(1'b1, 7'h02, 1'b0, 8'h00);
    key_row(1'b1, kcsm_pkg::CODE_FILE, 1'b0, 8'h00);
    key_row(1'b1, kcsm_pkg::CODE_Z, 1'b0, 8'h00);
    // same code for shift and Fn: shift wins
    keymap_row(8'h3A, 7'h3A);
    key_row(1'b1, 7'h3A, 1'b0, 8'h00);
    key_row(1'b1, 7'h3A, 1'b0, 8'h00);
    key_row(1'b1, 7'h62, 1'b0, 8'h00);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 19;
    pop_idle_pct  = 84;
    for (i = 0; i < script.size(); i++) begin
      row = script[i];
      if (row.is_cfg) write_keys(row.shift_val, row.fn_val);
      else send_event(row.ev, row.typed, row.ch);
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 19;
          pop_idle_pct  = 84;
        end
        1: begin
          send_idle_pct = 84;
          pop_idle_pct  = 19;
        end
        default: begin
          send_idle_pct = 0;
          pop_idle_pct  = 0;
        end
      endcase
      case (p)
        0:       write_keys(kcsm_pkg::SHIFT_KEY_RESET, kcsm_pkg::FN_KEY_RESET);
        1:       write_keys(8'h00, 7'h7F);
        2:       write_keys(8'hFF, 7'h00);
        3:       write_keys(8'h7F, 7'h7F);
        4:       write_keys(8'h80, kcsm_pkg::CODE_FILE);
        default: write_keys(8'($urandom_range(127)), 7'($urandom_range(127)));
      endcase
      repeat (PHASE_EVENTS) send_event(pick_event(), 1'b0, 8'h00);
    end

    in_push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS keycode_to_char_sticky_modifiers_top");
    end else begin
      $display("FAIL keycode_to_char_sticky_modifiers_top");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/kcsm_pkg.sv
rtl/core/kcsm_front.sv
rtl/core/kcsm_queue.sv
rtl/core/kcsm_back.sv
rtl/core/keycode_to_char_sticky_modifiers_top.sv
dv/keycode_to_char_sticky_modifiers_tb.sv
